@@ rtl/core/ppfc_pkg.sv @@
package ppfc_pkg;

	// widths
	localparam int COUNTER_BITS = 32;
	localparam int OFFSET_BITS  = 16;
	localparam int OUT_BITS     = 32;
	localparam int NUM_COUNTERS = 9;
	localparam int RESULT_BITS  = NUM_COUNTERS * OUT_BITS;
	// header positions reach at most 255 + 4*15 + 13, which needs 9 bits
	localparam int CMP_BITS     = (OFFSET_BITS > 9) ? OFFSET_BITS : 9;

	typedef logic [COUNTER_BITS-1:0] cnt_t;
	typedef logic [OFFSET_BITS-1:0]  off_t;
	typedef logic [CMP_BITS-1:0]     pos_t;

	// counter slots, in result order
	localparam int IDX_TOTAL   = 0;
	localparam int IDX_TCP     = 1;
	localparam int IDX_UDP     = 2;
	localparam int IDX_SYN     = 3;
	localparam int IDX_SYN_ACK = 4;
	localparam int IDX_ACK     = 5;
	localparam int IDX_FIN_ACK = 6;
	localparam int IDX_RST     = 7;
	localparam int IDX_RST_ACK = 8;

	// tcp flag bit positions
	localparam int FLAG_FIN = 0;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_RST = 2;
	localparam int FLAG_ACK = 4;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [7:0] IP_HDR_OFS     = 8'd9;
	localparam logic [7:0] TCP_FLAGS_OFS  = 8'd13;
	localparam logic [7:0] LINK_LEN_RESET = 8'd14;

	// register map (word index)
	localparam logic REG_LINK_LEN = 1'b0;

	// counter increments, packed so that bit i belongs to counter slot i
	typedef struct packed {
		logic rst_ack;
		logic rst;
		logic fin_ack;
		logic ack;
		logic syn_ack;
		logic syn;
		logic udp;
		logic tcp;
		logic total;
	} bump_t;

	function automatic logic [OUT_BITS-1:0] to_out(cnt_t c);
		logic [63:0] w;
		w = 64'(c);
		return w[OUT_BITS-1:0];
	endfunction

endpackage

@@ rtl/core/ppfc_parser.sv @@
module ppfc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [7:0]          link_header_length,
	output ppfc_pkg::bump_t     bump
);

	ppfc_pkg::off_t off_q, off_d;
	logic [3:0]     ihw_q, ihw_d;
	logic [7:0]     proto_q, proto_d;
	logic [7:0]     flags_q, flags_d;

	ppfc_pkg::pos_t off_c, base_c, flag_pos;
	logic           hdr_hit, proto_hit, flag_hit;
	logic           syn, ack, rst, fin, is_tcp;

	always_comb begin
		off_c    = ppfc_pkg::CMP_BITS'(off_q);
		base_c   = ppfc_pkg::CMP_BITS'(link_header_length);
		flag_pos = base_c + ppfc_pkg::CMP_BITS'({ihw_q, 2'b00})
			+ ppfc_pkg::CMP_BITS'(ppfc_pkg::TCP_FLAGS_OFS);
		hdr_hit   = off_c == base_c;
		proto_hit = off_c == base_c + ppfc_pkg::CMP_BITS'(ppfc_pkg::IP_HDR_OFS);
		flag_hit  = (off_c > base_c) && (off_c == flag_pos);

		// captures including the current word, so a last word can count itself
		ihw_d   = hdr_hit   ? data_byte[3:0] : ihw_q;
		proto_d = proto_hit ? data_byte      : proto_q;
		flags_d = flag_hit  ? data_byte      : flags_q;

		off_d = (&off_q) ? off_q : off_q + ppfc_pkg::OFFSET_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			ihw_q   <= '0;
			proto_q <= '0;
			flags_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				off_q   <= '0;
				ihw_q   <= '0;
				proto_q <= '0;
				flags_q <= '0;
			end else begin
				off_q   <= off_d;
				ihw_q   <= ihw_d;
				proto_q <= proto_d;
				flags_q <= flags_d;
			end
		end
	end

	// classification of the finished packet
	always_comb begin
		syn    = flags_d[ppfc_pkg::FLAG_SYN];
		ack    = flags_d[ppfc_pkg::FLAG_ACK];
		rst    = flags_d[ppfc_pkg::FLAG_RST];
		fin    = flags_d[ppfc_pkg::FLAG_FIN];
		is_tcp = proto_d == ppfc_pkg::PROTO_TCP;

		bump       = '0;
		bump.total = 1'b1;
		bump.tcp   = is_tcp;
		bump.udp   = proto_d == ppfc_pkg::PROTO_UDP;
		if (is_tcp) begin
			priority if (syn && ack) begin
				bump.syn_ack = 1'b1;
			end else if (fin && ack) begin
				bump.fin_ack = 1'b1;
			end else if (rst && ack) begin
				bump.rst_ack = 1'b1;
			end else begin
				bump.syn = syn;
				bump.ack = ack;
				bump.rst = rst;
			end
		end
	end

endmodule

@@ rtl/core/ppfc_counters.sv @@
module ppfc_counters (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  step,
	input  ppfc_pkg::bump_t                                       bump,
	output logic [ppfc_pkg::NUM_COUNTERS-1:0][ppfc_pkg::OUT_BITS-1:0] result
);

	ppfc_pkg::cnt_t                          cnt_q [ppfc_pkg::NUM_COUNTERS];
	ppfc_pkg::cnt_t                          cnt_d [ppfc_pkg::NUM_COUNTERS];
	logic [ppfc_pkg::NUM_COUNTERS-1:0]       inc;

	assign inc = bump;

	// saturating increment; result shows the counts after this packet
	always_comb begin
		for (int i = 0; i < ppfc_pkg::NUM_COUNTERS; i++) begin
			cnt_d[i]  = (inc[i] && !(&cnt_q[i])) ? cnt_q[i] + ppfc_pkg::COUNTER_BITS'(1)
				: cnt_q[i];
			result[i] = ppfc_pkg::to_out(cnt_d[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppfc_pkg::NUM_COUNTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (step) begin
			for (int i = 0; i < ppfc_pkg::NUM_COUNTERS; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
		end
	end

`ifndef SYNTHESIS
	// every tcp packet is also counted in total
	a_total_ge_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[ppfc_pkg::IDX_TOTAL] >= cnt_q[ppfc_pkg::IDX_TCP])
		else $error("tcp count exceeds total");

	// combined flag classes exclude each other and the single classes
	a_class_excl: assert property (@(posedge clk) disable iff (!arst_n)
		step && (bump.syn_ack || bump.fin_ack || bump.rst_ack) |->
			$onehot({bump.syn_ack, bump.fin_ack, bump.rst_ack})
			&& !bump.syn && !bump.ack && !bump.rst)
		else $error("flag classes overlap");
`endif

endmodule

@@ rtl/core/packet_protocol_flag_counter_unit.sv @@
// channel  | dir | handshake                  | payload
// s_*      | in  | s_tvalid / s_tready        | s_tdata[7:0] data_byte, s_tlast last_byte
// m_*      | out | m_tvalid / m_tready        | m_tdata: nine 32-bit counters
// apb      | in  | psel, penable, pready=1    | reg 0 at 0x0: link_header_length[7:0]
//
// one word per cycle while s_tready holds; each word passes the input register, and the
// counter update of a last word enters the result register as that word leaves it;
// every word but the last of a packet is consumed without a result
// s_tready drops only when a last word waits on a full, stalled result register
// reset clears position, captures, counters; link_header_length returns to 14
module packet_protocol_flag_counter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] data_byte
	input  logic                              s_tlast,   // last_byte
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] total_packets, [63:32] tcp_packets, [95:64] udp_packets,
	// [127:96] syn_count, [159:128] syn_ack_count, [191:160] ack_count,
	// [223:192] fin_ack_count, [255:224] rst_count, [287:256] rst_ack_count
	output logic [ppfc_pkg::RESULT_BITS-1:0]  m_tdata,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	// config register
	logic [7:0] link_len_q;
	logic       reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == ppfc_pkg::REG_LINK_LEN);
	assign prdata  = (reg_idx == ppfc_pkg::REG_LINK_LEN) ? 32'(link_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_len_q <= ppfc_pkg::LINK_LEN_RESET;
		end else if (cfg_wr) begin
			link_len_q <= pwdata[7:0];
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       s_fire;
	logic       advance;
	logic       emit;

	// a non-last word never waits; a last word needs room in the result register
	assign advance  = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign emit     = advance && last_s1;
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// header parsing and flag classification
	ppfc_pkg::bump_t bump;

	ppfc_parser u_parser (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (advance),
		.data_byte          (data_s1),
		.last_byte          (last_s1),
		.link_header_length (link_len_q),
		.bump               (bump)
	);

	// saturating statistics counters
	logic [ppfc_pkg::NUM_COUNTERS-1:0][ppfc_pkg::OUT_BITS-1:0] result;

	ppfc_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (emit),
		.bump   (bump),
		.result (result)
	);

	// result register
	logic m_valid_q;

	assign m_tvalid = m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= result;
		end
	end

`ifndef SYNTHESIS
	// a stalled result is never overwritten by a new packet end
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !emit)
		else $error("result overwritten while stalled");

	// a result only appears after a last word left the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result without packet end");
`endif

endmodule
